// File: src/local_maximum_peak_detector_top_assert.svh
// Assertion macros for the local-maximum peak detector.
// Included by the top level; no other dependencies.
`ifndef LOCAL_MAXIMUM_PEAK_DETECTOR_TOP_ASSERT_SVH
`define LOCAL_MAXIMUM_PEAK_DETECTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is asserted.
`define LMPD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define LMPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LMPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LMPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: src/lmpd_pkg.sv
// Shared constants, register codes and types of the local-maximum peak detector.
// No dependencies.
`timescale 1ns / 1ps

package lmpd_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int PIXEL_BITS_DEF = 16;

	localparam int DIM_W      = 13;  // width/height register
	localparam int SPAN_W     = 15;  // effective width, clamped to 1..MAX_WIDTH of the top level
	localparam int MARGIN_W   = 10;
	localparam int LEVEL_W    = 16;
	localparam int COORD_W    = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [DIM_W-1:0]    ROW_LIMIT    = 13'd4096;
	localparam logic [DIM_W-1:0]    DIM_RESET    = 13'd4096;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd50;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD,
		CFG_MARGIN,
		CFG_WIDTH,
		CFG_HEIGHT
	} cfg_idx_t;

	// effective (clamped) frame settings
	typedef struct packed {
		logic [LEVEL_W-1:0]  threshold;
		logic [MARGIN_W-1:0] margin;
		logic [SPAN_W-1:0]   width;
		logic [DIM_W-1:0]    height;
	} frame_cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [LEVEL_W-1:0] level;
	} peak_t;

endpackage

// File: src/lmpd_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// Uses lmpd_pkg for default sizes.
`timescale 1ns / 1ps

module lmpd_ram import lmpd_pkg::*; #(
	parameter int WIDTH = PIXEL_BITS_DEF,
	parameter int DEPTH = MAX_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/lmpd_pos.sv
// Column/row position counters of the incoming pixel stream.
// Uses lmpd_pkg (frame_cfg_t, widths).
`timescale 1ns / 1ps

module lmpd_pos import lmpd_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               frame_start,
	input  frame_cfg_t         cfg,
	output logic [AW-1:0]      col,
	output logic [COORD_W-1:0] row
);

	logic [AW-1:0]      col_q;
	logic [COORD_W-1:0] row_q;
	logic [AW-1:0]      c0, c1, col_n;
	logic [DIM_W-1:0]   r0, r1, r_inc;
	logic [SPAN_W-1:0]  c_inc;
	logic               wrap0, wrap1;
	logic [COORD_W-1:0] r, row_n;

	always_comb begin
		c0 = frame_start ? '0 : col_q;
		r0 = frame_start ? '0 : DIM_W'(row_q);
		// a column left beyond a narrowed width starts the next row
		wrap0 = SPAN_W'(c0) >= cfg.width;
		c1 = wrap0 ? '0 : c0;
		r1 = wrap0 ? r0 + 1'b1 : r0;
		r = (r1 >= cfg.height) ? '0 : r1[COORD_W-1:0];
		// advance for the next pixel
		c_inc = SPAN_W'(c1) + 1'b1;
		wrap1 = c_inc >= cfg.width;
		r_inc = DIM_W'(r) + 1'b1;
		col_n = wrap1 ? '0 : c_inc[AW-1:0];
		if (wrap1) begin
			row_n = (r_inc >= cfg.height) ? '0 : r_inc[COORD_W-1:0];
		end else begin
			row_n = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

	assign col = c1;
	assign row = r;

endmodule

// File: src/lmpd_nms.sv
// 3x3 window and non-maximum suppression test of the window center.
// Uses lmpd_pkg (frame_cfg_t, peak_t, widths).
`timescale 1ns / 1ps

module lmpd_nms import lmpd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  logic [AW-1:0]         col_s1,
	input  logic [COORD_W-1:0]    row_s1,
	input  logic [PIXEL_BITS-1:0] pix_s1,
	input  logic [PIXEL_BITS-1:0] above_s1,
	input  logic [PIXEL_BITS-1:0] above2_s1,
	input  frame_cfg_t            cfg,
	output logic                  valid_s2,
	output logic                  peak_valid,
	output peak_t                 peak
);

	localparam int CXW = SPAN_W + 1;
	localparam int CYW = DIM_W + 1;

	logic [PIXEL_BITS-1:0] win_q [9];
	logic [CXW-1:0]        cx, cx_end;
	logic [CYW-1:0]        cy, cy_end;
	logic                  in_region;
	logic                  valid_q_s2, tst_s2;
	logic [COORD_W-1:0]    col_s2, row_s2;
	logic [PIXEL_BITS-1:0] ctr;
	logic                  earlier_ok, later_ok, above_thr;

	// center sits one column left and one row up of the newest pixel
	always_comb begin
		cx = CXW'(col_s1) - 1'b1;
		cy = CYW'(row_s1) - 1'b1;
		cx_end = cx + CXW'(cfg.margin);
		cy_end = cy + CYW'(cfg.margin);
		in_region = (col_s1 != '0) && (row_s1 != '0) &&
			(cx >= CXW'(cfg.margin)) && (cx_end < CXW'(cfg.width)) &&
			(cy >= CYW'(cfg.margin)) && (cy_end < CYW'(cfg.height));
	end

	// shift the window left, new column enters at the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
			valid_q_s2 <= 1'b0;
			tst_s2     <= 1'b0;
		end else begin
			valid_q_s2 <= valid_s1;
			if (valid_s1) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= above2_s1;
				win_q[3] <= win_q[4];
				win_q[4] <= win_q[5];
				win_q[5] <= above_s1;
				win_q[6] <= win_q[7];
				win_q[7] <= win_q[8];
				win_q[8] <= pix_s1;
				tst_s2   <= in_region;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			col_s2 <= cx[COORD_W-1:0];
			row_s2 <= cy[COORD_W-1:0];
		end
	end

	// earlier neighbors strictly below, later neighbors not above
	always_comb begin
		ctr = win_q[4];
		earlier_ok = (win_q[0] < ctr) && (win_q[1] < ctr) &&
			(win_q[2] < ctr) && (win_q[3] < ctr);
		later_ok = (win_q[5] <= ctr) && (win_q[6] <= ctr) &&
			(win_q[7] <= ctr) && (win_q[8] <= ctr);
		above_thr = LEVEL_W'(ctr) > cfg.threshold;
		peak_valid = valid_q_s2 && tst_s2 && above_thr && earlier_ok && later_ok;
		peak.col = col_s2;
		peak.row = row_s2;
		peak.level = LEVEL_W'(ctr);
	end

	assign valid_s2 = valid_q_s2;

endmodule

// File: src/lmpd_outq.sv
// Small result queue between the test stage and the output channel.
// Uses lmpd_pkg (peak_t, OQ_DEPTH).
`timescale 1ns / 1ps

module lmpd_outq import lmpd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  peak_t               push_peak,
	input  logic                out_stall,
	output logic                out_valid,
	output peak_t               head,
	output logic [OQ_CNT_W-1:0] count
);

	localparam int PTR_W = $clog2(OQ_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(OQ_DEPTH - 1);

	peak_t               slot_q [OQ_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic                pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = slot_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_peak;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
		end
	end

endmodule

// File: src/local_maximum_peak_detector_top.sv
// Top level of the 3x3 local-maximum peak detector.
// Depends on lmpd_pkg, lmpd_ram, lmpd_pos, lmpd_nms, lmpd_outq and the assertion header.
`timescale 1ns / 1ps

// Streams one frame of pixels in raster order and reports every 3x3 local
// maximum inside the border margin as one word (column, row, level). The block
// takes one pixel per clock while in_stall is low: each pixel costs one read
// and one write on each of two line RAMs (one row of MAX_WIDTH pixels each),
// and the window test is one layer of compares, so nothing loops. The pixel
// completing a window goes through the RAM read on its accepting edge and
// the window shift; the test result then enters the result queue. After
// reset both line RAMs are cleared to zero, one entry per clock, so in_stall
// stays high until the last entry is cleared; configuration writes are
// taken during that time. Afterwards in_stall rises only when the four-word
// result queue, counting pixels still in flight, could overflow because the
// consumer holds out_stall. Write configuration only while the block is idle.
// Registers: 0 threshold (center must exceed it), 1 border margin (0 acts as
// 1), 2 frame width (clamped to 1..MAX_WIDTH), 3 frame height (clamped to
// 1..4096). frame_start forces the pixel to column 0, row 0.

`include "local_maximum_peak_detector_top_assert.svh"

module local_maximum_peak_detector_top import lmpd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [LEVEL_W-1:0]    pixel_value,
	input  logic                  frame_start,
	// peak output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_W-1:0]    peak_col,
	output logic [COORD_W-1:0]    peak_row,
	output logic [LEVEL_W-1:0]    peak_level,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int IFW = OQ_CNT_W + 1;
	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_WIDTH - 1);

	// configuration registers
	logic [LEVEL_W-1:0]  thr_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [DIM_W-1:0]    width_q, height_q;
	frame_cfg_t          cfg;

	// clearing sweep
	logic          clr_active_q;
	logic [AW-1:0] clr_addr_q;

	// accept stage
	logic                  accept;
	logic [PIXEL_BITS-1:0] pix;
	logic [AW-1:0]         pos_col;
	logic [COORD_W-1:0]    pos_row;

	// first pipeline stage: RAM data arrives
	logic                  valid_s1, fwd_s1;
	logic [AW-1:0]         col_s1;
	logic [COORD_W-1:0]    row_s1;
	logic [PIXEL_BITS-1:0] pix_s1, fwd_data_s1;
	logic [PIXEL_BITS-1:0] above, above2_raw, above2;

	// line RAM ports
	logic                  we1, we2;
	logic [AW-1:0]         waddr1, waddr2;
	logic [PIXEL_BITS-1:0] wdata1, wdata2;

	// test stage and queue
	logic                valid_s2, peak_valid;
	peak_t               peak, head;
	logic [OQ_CNT_W-1:0] oq_count;
	logic [IFW-1:0]      inflight;

	// clamp the registers into the values the datapath works with
	always_comb begin
		cfg.threshold = thr_q;
		cfg.margin    = (margin_q == '0) ? MARGIN_W'(1) : margin_q;
		if (width_q == '0) begin
			cfg.width = SPAN_W'(1);
		end else if (SPAN_W'(width_q) > SPAN_W'(MAX_WIDTH)) begin
			cfg.width = SPAN_W'(MAX_WIDTH);
		end else begin
			cfg.width = SPAN_W'(width_q);
		end
		if (height_q == '0) begin
			cfg.height = DIM_W'(1);
		end else if (height_q > ROW_LIMIT) begin
			cfg.height = ROW_LIMIT;
		end else begin
			cfg.height = height_q;
		end
	end

	// hold input while clearing, or while the queue might run out of room
	assign inflight = IFW'(oq_count) + IFW'(valid_s1) + IFW'(valid_s2);
	assign in_stall = clr_active_q || (inflight >= IFW'(OQ_DEPTH));
	assign accept   = in_valid && !in_stall;
	assign pix      = pixel_value[PIXEL_BITS-1:0];

	lmpd_pos #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_start(frame_start),
		.cfg        (cfg),
		.col        (pos_col),
		.row        (pos_row)
	);

	// RAM 1 holds row r-1: write the new pixel where the old one is read
	assign we1    = clr_active_q || accept;
	assign waddr1 = clr_active_q ? clr_addr_q : pos_col;
	assign wdata1 = clr_active_q ? '0 : pix;

	// RAM 2 holds row r-2: move the row r-1 pixel down once it is read
	assign we2    = clr_active_q || valid_s1;
	assign waddr2 = clr_active_q ? clr_addr_q : col_s1;
	assign wdata2 = clr_active_q ? '0 : above;

	lmpd_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line1 (
		.clk  (clk),
		.we   (we1),
		.waddr(waddr1),
		.wdata(wdata1),
		.raddr(pos_col),
		.rdata(above)
	);

	lmpd_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line2 (
		.clk  (clk),
		.we   (we2),
		.waddr(waddr2),
		.wdata(wdata2),
		.raddr(pos_col),
		.rdata(above2_raw)
	);

	// With a one-pixel row, back-to-back pixels hit the same column: the RAM 2
	// read happens on the edge that writes it, so take the value from stage 1.
	assign above2 = fwd_s1 ? fwd_data_s1 : above2_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= '0;
			margin_q     <= MARGIN_RESET;
			width_q      <= DIM_RESET;
			height_q     <= DIM_RESET;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			valid_s1     <= 1'b0;
			fwd_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_THRESHOLD: thr_q    <= cfg_data[LEVEL_W-1:0];
					CFG_MARGIN:    margin_q <= cfg_data[MARGIN_W-1:0];
					CFG_WIDTH:     width_q  <= cfg_data[DIM_W-1:0];
					CFG_HEIGHT:    height_q <= cfg_data[DIM_W-1:0];
					default:       ;
				endcase
			end
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == CLR_LAST) begin
					clr_active_q <= 1'b0;
				end
			end
			valid_s1 <= accept;
			if (accept) begin
				fwd_s1 <= valid_s1 && (pos_col == col_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= pos_col;
			row_s1      <= pos_row;
			pix_s1      <= pix;
			fwd_data_s1 <= above;
		end
	end

	lmpd_nms #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_nms (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.col_s1    (col_s1),
		.row_s1    (row_s1),
		.pix_s1    (pix_s1),
		.above_s1  (above),
		.above2_s1 (above2),
		.cfg       (cfg),
		.valid_s2  (valid_s2),
		.peak_valid(peak_valid),
		.peak      (peak)
	);

	lmpd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (peak_valid),
		.push_peak(peak),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.head     (head),
		.count    (oq_count)
	);

	assign peak_col   = head.col;
	assign peak_row   = head.row;
	assign peak_level = head.level;

	`LMPD_ASSERT_ALWAYS(a_stall_in_reset, clk, !arst_n |-> in_stall, "input open during reset")
	`LMPD_ASSERT(a_queue_room, clk, arst_n, peak_valid |-> oq_count < OQ_CNT_W'(OQ_DEPTH), "peak word pushed into a full queue")
	`LMPD_ASSERT(a_clear_done, clk, arst_n, $fell(clr_active_q) |-> $past(clr_addr_q) == CLR_LAST, "line clear ended early")
	`LMPD_ASSERT(a_s1_advance, clk, arst_n, valid_s1 |=> valid_s2, "stage 1 word lost")
	`LMPD_ASSERT(a_fwd_same_col, clk, arst_n, valid_s1 && fwd_s1 |-> col_s1 == $past(col_s1), "forward taken across columns")

endmodule
